[rtl/core/mcag_pkg.sv]
`default_nettype none
package mcag_pkg;

  // field widths fixed by the interface
  localparam int unsigned NUM_MOTORS = 4;
  localparam int unsigned MOTOR_W    = 18;
  localparam int unsigned WIRE_W     = 16;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;
  // positive magnitude of a motor value times the wire maximum
  localparam int unsigned PROD_W     = MOTOR_W - 1 + WIRE_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_READY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIRE_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_FRAMES = 3'd4;

  // requested arm states
  localparam logic [REQ_W-1:0] REQ_DISARMED = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ARMED    = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_NOT_READY     = 3'd1,
    ST_STATE_INVALID = 3'd2,
    ST_MIXER_INVALID = 3'd3,
    ST_VALUE_INVALID = 3'd4,
    ST_TX_BUSY       = 3'd5
  } status_e;

  typedef struct packed {
    logic                      link_ready;
    logic signed [MOTOR_W-1:0] value_min;
    logic signed [MOTOR_W-1:0] value_max;
    logic [WIRE_W-1:0]         wire_max;
    logic [WIRE_W-1:0]         guard_frames;
  } cfg_t;

  // decision stage result, everything but the wire values
  typedef struct packed {
    status_e           status;
    logic              sent;
    logic [SEQ_W-1:0]  seq;
    logic              armed;
    logic [WIRE_W-1:0] guard_left;
  } gate_t;

endpackage
`default_nettype wire

[rtl/core/mcag_cfg.sv]
`default_nettype none
module mcag_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mcag_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mcag_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output mcag_pkg::cfg_t                 cfg_o
);
  import mcag_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register file, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.link_ready   <= 1'b0;
      cfg_q.value_min    <= '0;
      cfg_q.value_max    <= 18'sh10000;
      cfg_q.wire_max     <= 16'd1000;
      cfg_q.guard_frames <= 16'd50;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LINK_READY:   cfg_q.link_ready   <= cfg_data_i[0];
        CFG_VALUE_MIN:    cfg_q.value_min    <= $signed(cfg_data_i[MOTOR_W-1:0]);
        CFG_VALUE_MAX:    cfg_q.value_max    <= $signed(cfg_data_i[MOTOR_W-1:0]);
        CFG_WIRE_MAX:     cfg_q.wire_max     <= cfg_data_i[WIRE_W-1:0];
        CFG_GUARD_FRAMES: cfg_q.guard_frames <= cfg_data_i[WIRE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/mcag_gate.sv]
`default_nettype none
module mcag_gate #(
  parameter int unsigned GUARD_WIDTH = 16
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  mcag_pkg::cfg_t                                         cfg_i,
  input  logic                                                   accept_i,
  input  logic                                                   command_i,
  input  logic [mcag_pkg::REQ_W-1:0]                             requested_state_i,
  input  logic [mcag_pkg::SEQ_W-1:0]                             sequence_req_i,
  input  logic                                                   mixer_valid_i,
  input  logic                                                   tx_busy_i,
  input  logic [mcag_pkg::NUM_MOTORS-1:0][mcag_pkg::MOTOR_W-1:0] motor_i,
  output mcag_pkg::gate_t                                        gate_o,
  output logic [mcag_pkg::NUM_MOTORS-1:0][mcag_pkg::PROD_W-1:0]  prod_o
);
  import mcag_pkg::*;

  localparam logic [31:0] GUARD_MAX = 32'((64'd1 << GUARD_WIDTH) - 64'd1);

  logic                                   armed_q, armed_d;
  logic [GUARD_WIDTH-1:0]                 guard_q, guard_d;
  logic [GUARD_WIDTH-1:0]                 guard_load;
  logic [31:0]                            guard_frames_ext;
  logic [31:0]                            guard_d_ext;
  logic                                   in_range;
  logic                                   scale_en;
  logic signed [MOTOR_W-1:0]              value;
  logic [NUM_MOTORS-1:0][MOTOR_W-2:0]     mag;
  logic [NUM_MOTORS-1:0][PROD_W-1:0]      prod_d;
  logic [NUM_MOTORS-1:0][PROD_W-1:0]      prod_q;
  gate_t                                  gate_d;
  gate_t                                  gate_q;

  // guard reload value, saturated to the counter width
  assign guard_frames_ext = 32'(cfg_i.guard_frames);
  assign guard_load = (guard_frames_ext > GUARD_MAX) ? GUARD_MAX[GUARD_WIDTH-1:0]
                                                     : guard_frames_ext[GUARD_WIDTH-1:0];

  // request decision, arm state update and scaling products
  always_comb begin
    armed_d        = armed_q;
    guard_d        = guard_q;
    in_range       = 1'b1;
    scale_en       = 1'b0;
    gate_d.status  = ST_OK;
    gate_d.sent    = 1'b0;
    gate_d.seq     = '0;
    gate_d.armed   = 1'b0;

    for (int k = 0; k < NUM_MOTORS; k++) begin
      value = $signed(motor_i[k]);
      if (value < $signed(cfg_i.value_min) || value > $signed(cfg_i.value_max)) begin
        in_range = 1'b0;
      end
    end

    if (!cfg_i.link_ready) begin
      gate_d.status = ST_NOT_READY;
    end else if (command_i) begin
      if (requested_state_i != REQ_DISARMED && requested_state_i != REQ_ARMED) begin
        gate_d.status = ST_STATE_INVALID;
      end else if ((requested_state_i == REQ_ARMED) != armed_q) begin
        armed_d = (requested_state_i == REQ_ARMED);
        guard_d = armed_d ? guard_load : '0;
      end
    end else begin
      if (!mixer_valid_i) begin
        gate_d.status = ST_MIXER_INVALID;
      end else if (!in_range) begin
        gate_d.status = ST_VALUE_INVALID;
      end else if (tx_busy_i) begin
        gate_d.status = ST_TX_BUSY;
      end else begin
        gate_d.sent  = 1'b1;
        gate_d.seq   = sequence_req_i;
        gate_d.armed = armed_q;
        // zero frames while disarmed or while the guard runs down
        scale_en     = armed_q && (guard_q == '0);
        if (armed_q && guard_q != '0) begin
          guard_d = guard_q - GUARD_WIDTH'(1);
        end
      end
    end

    // non-positive values and zero frames give a zero product
    for (int k = 0; k < NUM_MOTORS; k++) begin
      value     = $signed(motor_i[k]);
      mag[k]    = (scale_en && value > 0) ? value[MOTOR_W-2:0] : '0;
      prod_d[k] = PROD_W'(mag[k]) * PROD_W'(cfg_i.wire_max);
    end

    guard_d_ext       = 32'(guard_d);
    gate_d.guard_left = guard_d_ext[WIRE_W-1:0];
  end

  // arm state and stage one register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      guard_q <= '0;
      gate_q  <= '0;
      prod_q  <= '0;
    end else if (accept_i) begin
      armed_q <= armed_d;
      guard_q <= guard_d;
      gate_q  <= gate_d;
      prod_q  <= prod_d;
    end
  end

  assign gate_o = gate_q;
  assign prod_o = prod_q;

endmodule
`default_nettype wire

[rtl/core/mcag_scale.sv]
`default_nettype none
module mcag_scale #(
  parameter int unsigned VALUE_FRAC_BITS = 16
) (
  input  logic [mcag_pkg::PROD_W-1:0] prod_i,
  input  logic [mcag_pkg::WIRE_W-1:0] wire_max_i,
  output logic [mcag_pkg::WIRE_W-1:0] wire_o
);
  import mcag_pkg::*;

  localparam int unsigned SUM_W = PROD_W + 1;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (VALUE_FRAC_BITS - 1);

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] rounded;

  // round half up, then saturate to the wire maximum
  always_comb begin
    sum     = SUM_W'(prod_i) + HALF;
    rounded = sum >> VALUE_FRAC_BITS;
    if (rounded > SUM_W'(wire_max_i)) begin
      wire_o = wire_max_i;
    end else begin
      wire_o = rounded[WIRE_W-1:0];
    end
  end

endmodule
`default_nettype wire

[rtl/core/motor_command_arm_gate_core.sv]
// an accepted request is held in the stage one register, then in the result register
// throughput: one request per cycle, limited by nothing but output stall
// stage one makes the decision, updates arm state and multiplies, stage two rounds
// reset clears arm state, guard count, pipeline valids and loads register defaults
`default_nettype none
module motor_command_arm_gate_core #(
  parameter int unsigned VALUE_FRAC_BITS = 16,
  parameter int unsigned GUARD_WIDTH     = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mcag_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mcag_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [mcag_pkg::REQ_W-1:0]      requested_state_i,
  input  logic [mcag_pkg::SEQ_W-1:0]      sequence_req_i,
  input  logic                            mixer_valid_i,
  input  logic                            tx_busy_i,
  input  logic signed [mcag_pkg::MOTOR_W-1:0] motor_one_i,
  input  logic signed [mcag_pkg::MOTOR_W-1:0] motor_two_i,
  input  logic signed [mcag_pkg::MOTOR_W-1:0] motor_three_i,
  input  logic signed [mcag_pkg::MOTOR_W-1:0] motor_four_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mcag_pkg::STATUS_W-1:0]   status_o,
  output logic                            frame_sent_o,
  output logic [mcag_pkg::SEQ_W-1:0]      frame_sequence_o,
  output logic                            frame_armed_o,
  output logic [mcag_pkg::WIRE_W-1:0]     wire_one_o,
  output logic [mcag_pkg::WIRE_W-1:0]     wire_two_o,
  output logic [mcag_pkg::WIRE_W-1:0]     wire_three_o,
  output logic [mcag_pkg::WIRE_W-1:0]     wire_four_o,
  output logic [mcag_pkg::WIRE_W-1:0]     guard_left_o
);
  import mcag_pkg::*;

  cfg_t                               cfg;
  gate_t                              gate;
  logic [NUM_MOTORS-1:0][MOTOR_W-1:0] motor;
  logic [NUM_MOTORS-1:0][PROD_W-1:0]  prod;
  logic [NUM_MOTORS-1:0][WIRE_W-1:0]  wire_d;
  logic [NUM_MOTORS-1:0][WIRE_W-1:0]  wire_q;
  gate_t                              res_q;
  logic                               s1_valid_q, s1_valid_d;
  logic                               out_valid_q, out_valid_d;
  logic                               out_load;
  logic                               s1_advance;
  logic                               in_accept;

  assign motor[0] = motor_one_i;
  assign motor[1] = motor_two_i;
  assign motor[2] = motor_three_i;
  assign motor[3] = motor_four_i;

  // configuration registers
  mcag_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // pipeline handshake
  assign out_load   = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_advance = !s1_valid_q || out_load;
  assign in_stall_o = !s1_advance;
  assign in_accept  = in_valid_i && s1_advance;
  assign s1_valid_d = s1_advance ? in_valid_i : s1_valid_q;

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // decision stage with arm state and products
  mcag_gate #(
    .GUARD_WIDTH (GUARD_WIDTH)
  ) u_gate (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .accept_i          (in_accept),
    .command_i         (command_i),
    .requested_state_i (requested_state_i),
    .sequence_req_i    (sequence_req_i),
    .mixer_valid_i     (mixer_valid_i),
    .tx_busy_i         (tx_busy_i),
    .motor_i           (motor),
    .gate_o            (gate),
    .prod_o            (prod)
  );

  // rounding and saturation per motor
  for (genvar k = 0; k < NUM_MOTORS; k++) begin : g_scale
    mcag_scale #(
      .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
    ) u_scale (
      .prod_i     (prod[k]),
      .wire_max_i (cfg.wire_max),
      .wire_o     (wire_d[k])
    );
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q  <= gate;
      wire_q <= wire_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_q.status;
  assign frame_sent_o     = res_q.sent;
  assign frame_sequence_o = res_q.seq;
  assign frame_armed_o    = res_q.armed;
  assign wire_one_o       = wire_q[0];
  assign wire_two_o       = wire_q[1];
  assign wire_three_o     = wire_q[2];
  assign wire_four_o      = wire_q[3];
  assign guard_left_o     = res_q.guard_left;

endmodule
`default_nettype wire
